>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the interval averager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/iravg_pkg.sv
// Shared types and constants of the interval running averager.
package iravg_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W    = 2;
    localparam int TIME_W    = 32;
    localparam int ACC_W     = 40;
    localparam int SAMPLES_W = 9;
    localparam int COUNT_W   = 32;

    // Function codes carried by the input word.
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Step counter of the serial divider.
    localparam int DIV_STEP_W = $clog2(ACC_W);

    // Reciprocal multiply that removes one window-th of the accumulator.
    // The padded accumulator is fed in chunks, most significant first.
    localparam int MUL_CHUNK = 14;
    localparam int MUL_STEPS = 3;
    localparam int MUL_X_W   = MUL_CHUNK * MUL_STEPS;
    localparam int MSTEP_W   = 2;
    localparam int RECIP_W   = ACC_W + 2;
    localparam int PROD_W    = MUL_X_W + RECIP_W;

    // Decoded operation of one input word.
    typedef enum logic [1:0] {
        OP_START,
        OP_END,
        OP_QUERY
    } op_t;

    // One classified word as it waits in the queue.
    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
        logic              clear;
    } item_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN_MUL,
        ST_WIN_SUB,
        ST_AVG,
        ST_AVG_WAIT,
        ST_PUSH
    } state_t;

endpackage

>>> rtl/iravg_div.sv
// Restoring bit-serial divider, one quotient bit per clock cycle.
module iravg_div import iravg_pkg::*; #(
    parameter int DIVISOR_W = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [ACC_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [ACC_W-1:0]     quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [ACC_W-1:0]      quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quot_reg[ACC_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    // Control: count the steps and flag the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= DIV_STEP_W'(ACC_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[ACC_W-2:0], fits};
            rem_reg  <= fits ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                             : DIVISOR_W'(trial);
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/iravg_front.sv
// Front part: accepts input words, classifies them and queues them.
module iravg_front import iravg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [TIME_W-1:0] s_now,
    input  logic              s_clear,
    output logic              q_valid,
    input  logic              q_ready,
    output item_t             q_item
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;
    item_t             classified;

    // Decode the function code; clear only matters on a start.
    always_comb begin
        classified.now   = s_now;
        classified.clear = 1'b0;
        priority if (s_func == FUNC_START) begin
            classified.op    = OP_START;
            classified.clear = s_clear;
        end else if (s_func == FUNC_END) begin
            classified.op = OP_END;
        end else begin
            classified.op = OP_QUERY;
        end
    end

    assign s_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> rtl/iravg_back.sv
// Back part: updates the statistics, divides and drives the result word.
module iravg_back import iravg_pkg::*; #(
    parameter int WINDOW = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  item_t                q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TIME_W-1:0]    m_average,
    output logic [SAMPLES_W-1:0] m_samples,
    output logic [COUNT_W-1:0]   m_total_ends
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

    // Rounded-up reciprocal of the window, scaled so that the product with
    // any 40-bit accumulator, shifted right, gives the exact quotient.
    localparam int WIN_LOG2 = $clog2(WINDOW);
    localparam logic [63:0] WIN_RECIP_FULL =
        ((64'd1 << (ACC_W + WIN_LOG2)) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] WIN_RECIP = RECIP_W'(WIN_RECIP_FULL);

    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    start_time_reg, start_time_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COUNT_W-1:0]   endc_reg, endc_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    avg_reg, avg_next;
    logic [MUL_X_W-1:0]   mul_x_reg, mul_x_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MSTEP_W-1:0]   mstep_reg, mstep_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]    m_average_reg, m_average_next;
    logic [SAMPLES_W-1:0] m_samples_reg, m_samples_next;
    logic [COUNT_W-1:0]   m_total_ends_reg, m_total_ends_next;
    logic [RECIP_W+MUL_CHUNK-1:0] mul_part;
    logic [ACC_W-1:0]     win_quot;
    logic                 div_start;
    logic [CNT_W-1:0]     div_divisor;
    logic                 div_done;
    logic [ACC_W-1:0]     div_quot;

    iravg_div #(
        .DIVISOR_W(CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(acc_reg),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quot)
    );

    // One partial product of the reciprocal multiply, and the window-th it yields.
    assign mul_part = WIN_RECIP * mul_x_reg[MUL_X_W-1 -: MUL_CHUNK];
    assign win_quot = ACC_W'(prod_reg >> (ACC_W + WIN_LOG2));

    // State and statistics registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            start_time_reg <= '0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            endc_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            start_time_reg <= start_time_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            endc_reg       <= endc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        now_reg          <= now_next;
        avg_reg          <= avg_next;
        mul_x_reg        <= mul_x_next;
        prod_reg         <= prod_next;
        mstep_reg        <= mstep_next;
        m_average_reg    <= m_average_next;
        m_samples_reg    <= m_samples_next;
        m_total_ends_reg <= m_total_ends_next;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next        = state_reg;
        start_time_next   = start_time_reg;
        acc_next          = acc_reg;
        cnt_next          = cnt_reg;
        endc_next         = endc_reg;
        now_next          = now_reg;
        avg_next          = avg_reg;
        mul_x_next        = mul_x_reg;
        prod_next         = prod_reg;
        mstep_next        = mstep_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_average_next    = m_average_reg;
        m_samples_next    = m_samples_reg;
        m_total_ends_next = m_total_ends_reg;
        q_ready           = 1'b0;
        div_start         = 1'b0;
        div_divisor       = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_ready  = 1'b1;
                    now_next = q_item.now;
                    unique case (q_item.op)
                        OP_START: begin
                            if (q_item.clear) begin
                                acc_next  = '0;
                                cnt_next  = '0;
                                endc_next = '0;
                            end
                            start_time_next = q_item.now;
                            state_next      = ST_AVG;
                        end
                        OP_END: begin
                            endc_next = endc_reg + 1'b1;
                            if (cnt_reg >= WIN_CNT) begin
                                // Full window: first remove one window-th.
                                mul_x_next = MUL_X_W'(acc_reg);
                                prod_next  = '0;
                                mstep_next = '0;
                                state_next = ST_WIN_MUL;
                            end else begin
                                acc_next   = acc_reg
                                           + ACC_W'(TIME_W'(q_item.now - start_time_reg));
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = ST_AVG;
                            end
                        end
                        default: begin
                            state_next = ST_AVG;
                        end
                    endcase
                end
            end
            ST_WIN_MUL: begin
                // Multiply by the reciprocal one chunk per cycle.
                prod_next  = (prod_reg << MUL_CHUNK) + PROD_W'(mul_part);
                mul_x_next = mul_x_reg << MUL_CHUNK;
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == MSTEP_W'(MUL_STEPS - 1)) begin
                    state_next = ST_WIN_SUB;
                end
            end
            ST_WIN_SUB: begin
                acc_next   = acc_reg - win_quot
                           + ACC_W'(TIME_W'(now_reg - start_time_reg));
                state_next = ST_AVG;
            end
            ST_AVG: begin
                if (cnt_reg == '0) begin
                    avg_next   = '0;
                    state_next = ST_PUSH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    avg_next   = div_quot[TIME_W-1:0];
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // Load the output register once it is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_average_next    = avg_reg;
                    m_samples_next    = SAMPLES_W'(cnt_reg);
                    m_total_ends_next = endc_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_average    = m_average_reg;
    assign m_samples    = m_samples_reg;
    assign m_total_ends = m_total_ends_reg;

endmodule

>>> rtl/interval_running_average.sv
// Top level of the interval running averager.
//
// Input channel (s_valid/s_ready): one word per event. s_func selects start,
// end or query; s_now is the free-running time; s_clear on a start clears
// the statistics before the time is latched.
// Output channel (m_valid/m_ready): one word per input word, in order, with
// the average of the held intervals, the samples held and the end count.
// The average is formed by the 40-step serial divider; when no sample is
// held the divider is skipped and a zero average is given. An end word with
// a full window first removes one window-th of the accumulator by a
// three-step reciprocal multiply. Words are worked on one at a time; the
// back part takes no new word until the last one is loaded into the
// output register.
// A two-word queue in front lets the source hand over words while the back
// part divides, and the output register lets a finished word wait for the
// receiver; a stalled receiver holds the back part only once its next word
// is ready, and the queue keeps accepting until it is full.
// Reset (synchronous, active low) clears the start time, accumulator,
// sample count, end count, queue and output valid.
module interval_running_average import iravg_pkg::*; #(
    parameter int WINDOW = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [TIME_W-1:0]    s_now,
    input  logic                 s_clear,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TIME_W-1:0]    m_average,
    output logic [SAMPLES_W-1:0] m_samples,
    output logic [COUNT_W-1:0]   m_total_ends
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // Front part: accept and classify.
    iravg_front u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .s_now  (s_now),
        .s_clear(s_clear),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_item (q_item)
    );

    // Back part: update, divide, deliver.
    iravg_back #(
        .WINDOW(WINDOW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average),
        .m_samples   (m_samples),
        .m_total_ends(m_total_ends)
    );

endmodule

>>> rtl/iravg_checker.sv
// Port-level checker of the interval running averager and its bind.
`include "assert_macros.svh"

module iravg_checker #(
    parameter int WINDOW = 256
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_func,
    input logic [31:0] s_now,
    input logic        s_clear,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_average,
    input logic [8:0]  m_samples,
    input logic [31:0] m_total_ends
);

    // Windows too large for the samples field are not range checked.
    localparam bit BIG_WIN = WINDOW > 511;

    logic [72:0] out_word;
    logic        empty_word;

    assign out_word   = {m_average, m_samples, m_total_ends};
    assign empty_word = m_valid && (m_samples == '0);

    // A stalled result word stays offered.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)

    // A stalled result word keeps its payload.
    `ASSERT_CLK(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(out_word))

    // The window never holds more samples than its size.
    `ASSERT_CLK(a_samples_max, aclk, aresetn, m_valid |-> BIG_WIN || (m_samples <= WINDOW))

    // An empty window reports a zero average.
    `ASSERT_CLK(a_empty_avg, aclk, aresetn, empty_word |-> BIG_WIN || (m_average == '0))

    // Reset leaves no result word offered.
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule

bind interval_running_average iravg_checker #(.WINDOW(WINDOW)) u_iravg_checker (.*);
